// ----- src/exact_pattern_match_stream_defines.svh -----
// Assertion macros for the exact pattern match stream block.
// Included by files that carry concurrent checks; needs clk and rst in scope.
`ifndef EXACT_PATTERN_MATCH_STREAM_DEFINES_SVH
`define EXACT_PATTERN_MATCH_STREAM_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define EPMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define EPMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/epms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the exact pattern match stream block.
// No dependencies.
package epms_pkg;

  localparam int SYM_W  = 8;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;
  localparam int POS_W  = 32;
  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam int PATTERN_MAX_DEFAULT   = 64;
  localparam int ALPHABET_SIZE_DEFAULT = 256;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TEXT  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0]     LEN_RESET  = 7'd1;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             load;
    logic             text;
    logic             clear;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] index;
    logic [LEN_W-1:0] length;
  } epms_cmd_t;

endpackage

// ----- src/epms_cell.sv -----
`timescale 1ns / 1ps
// One pattern position: stored pattern byte and its prefix bit.
// Depends on epms_pkg.
module epms_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  epms_pkg::epms_cmd_t cmd,
  input  logic               prev_bit,
  output logic               bit_q,
  output logic               bit_next
);
  import epms_pkg::*;

  localparam logic [7:0] IDX_B = 8'(IDX);

  logic [SYM_W-1:0] pattern_byte;
  logic             active;
  logic             hit;

  assign active = {1'b0, cmd.length} > IDX_B;
  assign hit    = active && (pattern_byte == cmd.symbol) && prev_bit;

  always_comb begin
    bit_next = bit_q;
    if (cmd.clear) begin
      bit_next = 1'b0;
    end else if (cmd.text) begin
      bit_next = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && ({2'b00, cmd.index} == IDX_B)) begin
      pattern_byte <= cmd.symbol;
    end
  end

endmodule

// ----- src/epms_cfg.sv -----
`timescale 1ns / 1ps
// APB register file: pattern length.
// Depends on epms_pkg.
module epms_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [epms_pkg::ADDR_W-1:0] paddr,
  input  logic [epms_pkg::DATA_W-1:0] pwdata,
  output logic [epms_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [epms_pkg::LEN_W-1:0]  pattern_length
);
  import epms_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_RESET;
    end else if (wr_en && (reg_idx == REG_LENGTH)) begin
      pattern_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, pattern_length};
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- src/exact_pattern_match_stream.sv -----
`timescale 1ns / 1ps
// Exact pattern match stream: top level.
// Depends on epms_pkg, epms_cell, epms_cfg and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries op, symbol and pattern_index.
//   op load writes pattern byte pattern_index; op new-text clears the match
//   history and the byte position; op text feeds one text byte and yields one
//   result transfer (match, end_position) on the output channel.
//   pattern_length is written over the APB port at address 0, while idle.
//   Each text byte passes the row of cells, one cell per pattern position,
//   each comparing its byte and taking its neighbour's prefix bit; the
//   result sits in the output register the next cycle.
//   Throughput is one item per cycle while out_ready is high. A stalled
//   result is held in the output register and in_ready drops until it is
//   taken, so nothing is lost.
//   Reset clears the prefix history, the position count and out_valid, and
//   sets pattern_length to 1. Pattern bytes are undefined until loaded.
`include "exact_pattern_match_stream_defines.svh"
module exact_pattern_match_stream #(
  parameter int PATTERN_MAX   = epms_pkg::PATTERN_MAX_DEFAULT,
  parameter int ALPHABET_SIZE = epms_pkg::ALPHABET_SIZE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [epms_pkg::OP_W-1:0]   op,
  input  logic [epms_pkg::SYM_W-1:0]  symbol,
  input  logic [epms_pkg::IDX_W-1:0]  pattern_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        match,
  output logic [epms_pkg::POS_W-1:0]  end_position,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [epms_pkg::ADDR_W-1:0] paddr,
  input  logic [epms_pkg::DATA_W-1:0] pwdata,
  output logic [epms_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import epms_pkg::*;

  localparam int PIDX_W = $clog2(PATTERN_MAX);
  localparam int LEN_CAP = (PATTERN_MAX > 127) ? 127 : PATTERN_MAX;
  localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

  logic [LEN_W-1:0]       pattern_length;
  logic [LEN_W-1:0]       len_eff;
  logic [8:0]             top_wide;
  logic [PIDX_W-1:0]      top_idx;
  logic [SYM_W-1:0]       sym_table [256];
  logic                   in_xfer;
  logic                   is_load;
  logic                   is_text;
  logic                   is_clear;
  epms_cmd_t              cmd;
  logic [PATTERN_MAX-1:0] prefix_q;
  logic [PATTERN_MAX-1:0] prefix_next;
  logic [POS_W-1:0]       pos_cnt;
  logic                   hit;

  epms_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pattern_length (pattern_length)
  );

  for (genvar g = 0; g < 256; g++) begin : g_sym
    assign sym_table[g] = SYM_W'(g % ALPHABET_SIZE);
  end

  assign len_eff  = (pattern_length > LEN_CAP_V) ? LEN_CAP_V : pattern_length;
  assign top_wide = {2'b00, len_eff} - 9'd1;
  assign top_idx  = top_wide[PIDX_W-1:0];

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    is_load  = 1'b0;
    is_text  = 1'b0;
    is_clear = 1'b0;
    unique case (op)
      OP_LOAD:  is_load  = in_xfer;
      OP_TEXT:  is_text  = in_xfer;
      OP_CLEAR: is_clear = in_xfer;
      default:  ;
    endcase
  end

  assign cmd.load   = is_load;
  assign cmd.text   = is_text;
  assign cmd.clear  = is_clear;
  assign cmd.symbol = sym_table[symbol];
  assign cmd.index  = pattern_index;
  assign cmd.length = len_eff;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic prev_bit;
    if (i == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_link
      assign prev_bit = prefix_q[i-1];
    end
    epms_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .prev_bit (prev_bit),
      .bit_q    (prefix_q[i]),
      .bit_next (prefix_next[i])
    );
  end

  assign hit = (len_eff != '0) && prefix_next[top_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (is_clear) begin
        pos_cnt <= '0;
      end else if (is_text) begin
        pos_cnt <= pos_cnt + 1'b1;
      end
      if (is_text) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_text) begin
      match        <= hit;
      end_position <= pos_cnt;
    end
  end

  `EPMS_ASSERT_NEXT(a_text_gives_result, is_text, out_valid, "text transfer gave no result")
  `EPMS_ASSERT_NEXT(a_position_order, is_text, end_position == $past(pos_cnt), "bad position")
  `EPMS_ASSERT_NEXT(a_clear_state, is_clear, (pos_cnt == '0) && (prefix_q == '0), "not cleared")

endmodule

// ----- bench/exact_pattern_match_stream_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for exact_pattern_match_stream: a directed table, then random pattern
// loads, planted occurrences and stalls; a bit-level predictor checks all but typed rows.
// Needs epms_pkg and the block's RTL; reads no files.
module exact_pattern_match_stream_tb;
  import epms_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PMAX = PATTERN_MAX_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASE_ITEMS = 150;
  localparam logic [LEN_W-1:0] PHASE_LENGTHS [8] =
    '{7'd2, 7'd3, 7'd0, 7'd64, 7'd127, 7'd1, 7'd63, 7'd5};

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } match_rec_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] idx;
    logic             typed;
    logic             hit;
    logic [POS_W-1:0] pos;
  } row_t;

  // pattern_length stays at its reset value of 1 throughout this table
  localparam row_t DIRECTED_ROWS [22] = '{
    '{OP_LOAD,   8'h00, 6'd0,  1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'h00, 6'd0,  1'b1, 1'b1, 32'd0},
    '{OP_TEXT,   8'hFF, 6'd63, 1'b1, 1'b0, 32'd1},
    '{OP_LOAD,   8'hFF, 6'd0,  1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'hFF, 6'd0,  1'b1, 1'b1, 32'd2},
    '{OP_UNUSED, 8'hFF, 6'd63, 1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'h00, 6'd0,  1'b1, 1'b0, 32'd3},
    '{OP_CLEAR,  8'hFF, 6'd63, 1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'hFF, 6'd0,  1'b1, 1'b1, 32'd0},
    '{OP_LOAD,   8'hA5, 6'd63, 1'b0, 1'b0, 32'd0},
    '{OP_LOAD,   8'h5A, 6'd1,  1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'h5A, 6'd0,  1'b1, 1'b0, 32'd1},
    '{OP_TEXT,   8'hFF, 6'd0,  1'b1, 1'b1, 32'd2},
    '{OP_UNUSED, 8'h00, 6'd0,  1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'h80, 6'd0,  1'b1, 1'b0, 32'd3},
    '{OP_CLEAR,  8'h00, 6'd0,  1'b0, 1'b0, 32'd0},
    '{OP_LOAD,   8'h80, 6'd0,  1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'h80, 6'd0,  1'b1, 1'b1, 32'd0},
    '{OP_TEXT,   8'h7F, 6'd0,  1'b0, 1'b0, 32'd0},
    '{OP_LOAD,   8'h01, 6'd2,  1'b0, 1'b0, 32'd0},
    '{OP_LOAD,   8'hFE, 6'd3,  1'b0, 1'b0, 32'd0},
    '{OP_TEXT,   8'h01, 6'd0,  1'b0, 1'b0, 32'd0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op = OP_LOAD;
  logic [SYM_W-1:0]  symbol = '0;
  logic [IDX_W-1:0]  pattern_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              match;
  logic [POS_W-1:0]  end_position;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  exact_pattern_match_stream i_dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [SYM_W-1:0] shadow_pattern [PMAX];
  logic [PMAX-1:0]  shadow_prefix;
  logic [POS_W-1:0] shadow_pos;
  logic [LEN_W-1:0] shadow_len;

  match_rec_t results_due [$];
  match_rec_t due;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int lengths_set = 0;
  int cycle_count = 0;
  int sink_hold = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  bit narrow = 1'b0;
  logic [SYM_W-1:0] sym_a, sym_b;

  function automatic int span_of(input logic [LEN_W-1:0] l);
    return (l > PMAX) ? PMAX : int'(l);
  endfunction

  function automatic bit predict_match(input logic [OP_W-1:0] o, input logic [SYM_W-1:0] s,
                                       input logic [IDX_W-1:0] x, output match_rec_t r);
    logic [PMAX-1:0] keep;
    int span;
    keep = '0;
    span = span_of(shadow_len);
    r = '0;
    case (o)
      OP_LOAD: shadow_pattern[x] = s;
      OP_CLEAR: begin
        shadow_prefix = '0;
        shadow_pos = '0;
      end
      OP_TEXT: begin
        for (int i = 0; i < span; i++) keep[i] = (shadow_pattern[i] == s);
        shadow_prefix = ((shadow_prefix << 1) | PMAX'(1)) & keep;
        r.hit = (span > 0) ? shadow_prefix[span-1] : 1'b0;
        r.pos = shadow_pos;
        shadow_pos = shadow_pos + 1'b1;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (src_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SYM_W-1:0] pick_sym();
    if (narrow) return $urandom_range(0, 1) ? sym_a : sym_b;
    return SYM_W'($urandom);
  endfunction

  task automatic send(input logic [OP_W-1:0] o, input logic [SYM_W-1:0] s,
                      input logic [IDX_W-1:0] x, input logic typed, input match_rec_t want);
    match_rec_t r;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o;
    symbol <= s;
    pattern_index <= x;
    do @(posedge clk); while (!in_ready);
    if (predict_match(o, s, x, r)) results_due.push_back(typed ? want : r);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] l);
    drain_wait();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_LENGTH, 2'b00};
    pwdata <= DATA_W'(l);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_len = l;
    lengths_set++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // result sink: mostly ready, short stalls, now and then a long one
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_steady || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transfer: match=%0b end_position=%0d", match, end_position);
        errors++;
      end else begin
        due = results_due.pop_front();
        if (match !== due.hit) begin
          $error("match: expected %0b, got %0b", due.hit, match);
          errors++;
        end
        if (end_position !== due.pos) begin
          $error("end_position: expected %0d, got %0d", due.pos, end_position);
          errors++;
        end
        results_checked++;
        if (due.hit) hits_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("exact_pattern_match_stream_tb: done, errors");
      $finish;
    end
  end

  initial begin
    match_rec_t none;
    int span, n, roll, phase, base, phase_end;
    logic [LEN_W-1:0] next_len;
    none = '0;
    foreach (shadow_pattern[i]) shadow_pattern[i] = '0;
    shadow_prefix = '0;
    shadow_pos = '0;
    shadow_len = LEN_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[k])
      send(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].sym, DIRECTED_ROWS[k].idx,
           DIRECTED_ROWS[k].typed, {DIRECTED_ROWS[k].hit, DIRECTED_ROWS[k].pos});

    base = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      next_len = (phase < 8) ? PHASE_LENGTHS[phase] : LEN_W'($urandom_range(0, 127));
      narrow = $urandom_range(0, 1);
      sym_a = SYM_W'($urandom);
      sym_b = sym_a ^ (SYM_W'(1) << $urandom_range(0, SYM_W - 1));
      src_steady = (phase % 3 == 1);
      sink_steady = src_steady;
      span = span_of(next_len);
      // every position in use is written before the new length takes effect
      for (int i = 0; i < span; i++) send(OP_LOAD, pick_sym(), IDX_W'(i), 1'b0, none);
      set_length(next_len);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          n = span;
          if (span > 1 && $urandom_range(0, 3) == 0) n = $urandom_range(1, span - 1);
          if (n == 0) send(OP_TEXT, pick_sym(), IDX_W'($urandom), 1'b0, none);
          for (int i = 0; i < n; i++)
            send(OP_TEXT, shadow_pattern[i], IDX_W'($urandom), 1'b0, none);
        end else if (roll < 75) begin
          send(OP_TEXT, pick_sym(), IDX_W'($urandom), 1'b0, none);
        end else if (roll < 85) begin
          send(OP_TEXT, SYM_W'($urandom), IDX_W'($urandom), 1'b0, none);
        end else if (roll < 90) begin
          send(OP_CLEAR, SYM_W'($urandom), IDX_W'($urandom), 1'b0, none);
        end else if (roll < 95) begin
          send(OP_LOAD, pick_sym(), IDX_W'($urandom), 1'b0, none);
        end else if (roll < 98) begin
          send(OP_UNUSED, SYM_W'($urandom), IDX_W'($urandom), 1'b0, none);
        end else begin
          drain_wait();
        end
      end
      phase++;
    end

    drain_wait();
    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      errors++;
    end
    $display("covered %0d input transfers over %0d length settings (%0d phases)",
             items_sent, lengths_set, phase);
    $display("checked %0d result transfers, %0d of them matches", results_checked, hits_seen);
    if (errors == 0) begin
      $display("exact_pattern_match_stream_tb: done, clean");
    end else begin
      $display("exact_pattern_match_stream_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- exact_pattern_match_stream.f -----
+incdir+src
src/epms_pkg.sv
src/epms_cell.sv
src/epms_cfg.sv
src/exact_pattern_match_stream.sv
bench/exact_pattern_match_stream_tb.sv
